// File: design/mrof_pkg.sv
// shared types and constants for the multi-reader overwrite fifo
// no dependencies; imported by mrof_ctrl, the top level and the testbench
package mrof_pkg;

   localparam int DEPTH      = 1024;
   localparam int READERS    = 4;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int RIDX_W  = (READERS > 1) ? $clog2(READERS) : 1;

   // fixed port field widths
   localparam int ID_FIELD_W    = 3;
   localparam int DATA_FIELD_W  = 32;
   localparam int COUNT_FIELD_W = 11;
   localparam int MASK_FIELD_W  = 4;
   localparam int MASK_READERS  = (READERS < MASK_FIELD_W) ? READERS : MASK_FIELD_W;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BAD_ID = 2'd2
   } status_type;

   typedef struct packed {
      logic                    rd_ok;
      status_type              status;
      logic [CNT_W-1:0]        count;
      logic [MASK_FIELD_W-1:0] omask;
   } result_type;

endpackage

// File: design/mrof_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependencies
module mrof_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/mrof_ctrl.sv
// write pointer, per-reader index and count registers, and result decode
// depends on mrof_pkg
module mrof_ctrl
   import mrof_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  action_type            action,
   input  logic [ID_FIELD_W-1:0] reader_sel,
   output logic                  ram_wr_en,
   output logic [ADDR_W-1:0]     ram_wr_addr,
   output logic                  ram_rd_en,
   output logic [ADDR_W-1:0]     ram_rd_addr,
   output result_type            result
);

   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] idx_ff [READERS];
   logic [ADDR_W-1:0] idx_in [READERS];
   logic [CNT_W-1:0]  cnt_ff [READERS];
   logic [CNT_W-1:0]  cnt_in [READERS];
   logic [READERS-1:0] full;
   logic              id_ok;
   logic [RIDX_W-1:0] rid;
   logic [ADDR_W-1:0] nwp;
   logic [ADDR_W-1:0] cur_idx;
   logic [CNT_W-1:0]  cur_cnt;
   logic              rd_ok;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
      return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign id_ok   = (int'(reader_sel) < READERS);
   assign rid     = RIDX_W'(reader_sel);
   assign nwp     = next_slot(wp_ff);
   assign cur_idx = idx_ff[rid];
   assign cur_cnt = cnt_ff[rid];
   assign rd_ok   = (action == ACT_READ) && id_ok && (cur_cnt != '0);

   always_comb begin
      for (int r = 0; r < READERS; r++) begin
         full[r] = (cnt_ff[r] == CNT_W'(DEPTH));
      end
   end

   // next state
   always_comb begin
      wp_in = wp_ff;
      for (int r = 0; r < READERS; r++) begin
         idx_in[r] = idx_ff[r];
         cnt_in[r] = cnt_ff[r];
      end
      if (take) begin
         if (action == ACT_WRITE) begin
            wp_in = nwp;
            for (int r = 0; r < READERS; r++) begin
               if (full[r]) begin
                  // oldest element lost, reader follows the writer
                  idx_in[r] = nwp;
               end else begin
                  cnt_in[r] = cnt_ff[r] + 1'b1;
               end
            end
         end else if (rd_ok) begin
            idx_in[rid] = next_slot(cur_idx);
            cnt_in[rid] = cur_cnt - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         for (int r = 0; r < READERS; r++) begin
            idx_ff[r] <= '0;
            cnt_ff[r] <= '0;
         end
      end else begin
         wp_ff <= wp_in;
         for (int r = 0; r < READERS; r++) begin
            idx_ff[r] <= idx_in[r];
            cnt_ff[r] <= cnt_in[r];
         end
      end
   end

   // result of the current item, seen before the state update
   always_comb begin
      result        = '0;
      result.status = ST_OK;
      if (action == ACT_WRITE) begin
         for (int r = 0; r < MASK_READERS; r++) begin
            result.omask[r] = full[r];
         end
         if (id_ok) begin
            result.count = full[rid] ? cur_cnt : cur_cnt + 1'b1;
         end else begin
            result.status = ST_BAD_ID;
         end
      end else if (!id_ok) begin
         result.status = ST_BAD_ID;
      end else if (cur_cnt == '0) begin
         result.status = ST_EMPTY;
      end else begin
         result.rd_ok = 1'b1;
         result.count = cur_cnt - 1'b1;
      end
   end

   assign ram_wr_en   = take && (action == ACT_WRITE);
   assign ram_wr_addr = wp_ff;
   assign ram_rd_en   = take && rd_ok;
   assign ram_rd_addr = cur_idx;

endmodule

// File: design/multi_reader_overwrite_fifo.sv
// top level of the multi-reader overwrite fifo: handshake and result register
// depends on mrof_pkg, mrof_ctrl and mrof_ram
//
// One writer and several readers share a ring of DEPTH elements. Each request
// transfer is either a write (stores req_write_data, advances the write
// pointer, bumps each non-full reader's count, overruns full readers) or a
// read for reader req_reader_sel (returns its oldest element and consumes it).
// Every request gives exactly one response transfer with read data, status,
// the addressed reader's count after the step and the overrun mask.
// The response is registered: valid in the cycle after the request transfer.
// Throughput: one request per cycle when not stalled; state and ram update at the
// transfer edge, ram read data is registered and lines up with the response register.
// When the receiver stalls, the response register and ram read data hold and
// req_ready stays low until the response is taken; a new request is taken in
// the same cycle the waiting response leaves.
// Reset clears the write pointer, reader indexes and counts and the response
// valid; the element ram is not cleared and needs no clearing pass.
module multi_reader_overwrite_fifo
   import mrof_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   input  logic [ID_FIELD_W-1:0]    req_reader_sel,
   input  logic [DATA_FIELD_W-1:0]  req_write_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DATA_FIELD_W-1:0]  rsp_read_data,
   output logic [1:0]               rsp_status,
   output logic [COUNT_FIELD_W-1:0] rsp_available_count,
   output logic [MASK_FIELD_W-1:0]  rsp_overrun_mask
);

   logic              take;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result;
   result_type        res_ff;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_q;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   mrof_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .action      (action_type'(req_action)),
      .reader_sel  (req_reader_sel),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .result      (result)
   );

   mrof_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (DATA_WIDTH'(req_write_data)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = res_ff.rd_ok ? DATA_FIELD_W'(ram_q) : '0;
   assign rsp_status          = res_ff.status;
   assign rsp_available_count = COUNT_FIELD_W'(res_ff.count);
   assign rsp_overrun_mask    = res_ff.omask;

endmodule

// File: test/multi_reader_overwrite_fifo_tb.sv
// self-checking testbench for the multi-reader overwrite fifo
// depends on mrof_pkg and multi_reader_overwrite_fifo; predicts every response in-line
`timescale 1ns / 100ps

module multi_reader_overwrite_fifo_tb;
   import mrof_pkg::*;

   typedef struct {
      action_type               action;
      logic [ID_FIELD_W-1:0]    reader_sel;
      logic [DATA_FIELD_W-1:0]  write_data;
   } fifo_request_type;

   typedef struct packed {
      logic [DATA_FIELD_W-1:0]  read_data;
      status_type               status;
      logic [COUNT_FIELD_W-1:0] count;
      logic [MASK_FIELD_W-1:0]  mask;
   } fifo_response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_action = 1'b0;
   logic [ID_FIELD_W-1:0]    req_reader_sel = '0;
   logic [DATA_FIELD_W-1:0]  req_write_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [DATA_FIELD_W-1:0]  rsp_read_data;
   logic [1:0]               rsp_status;
   logic [COUNT_FIELD_W-1:0] rsp_available_count;
   logic [MASK_FIELD_W-1:0]  rsp_overrun_mask;

   multi_reader_overwrite_fifo dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_reader_sel      (req_reader_sel),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_status          (rsp_status),
      .rsp_available_count (rsp_available_count),
      .rsp_overrun_mask    (rsp_overrun_mask)
   );

   // shadow copy of the ring and the per-reader bookkeeping
   logic [DATA_FIELD_W-1:0]  ring [DEPTH];
   logic [ADDR_W-1:0]        wr_ptr;
   logic [ADDR_W-1:0]        rd_idx [READERS];
   logic [COUNT_FIELD_W-1:0] avail [READERS];

   fifo_request_type  pending_requests [$];
   fifo_response_type owed_responses [$];
   fifo_response_type want;

   int  failures = 0;
   int  rsp_seen = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;
   bit  hold_off = 1'b0;
   int  tx_gap = 0;
   int  tx_burst = 0;
   int  rx_stall = 0;
   int  rx_burst = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] step_ptr(logic [ADDR_W-1:0] p);
      return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic fifo_response_type next_response(action_type act,
                                                       logic [ID_FIELD_W-1:0] id,
                                                       logic [DATA_FIELD_W-1:0] data);
      fifo_response_type r;
      logic              id_ok;
      r = '0;
      r.status = ST_OK;
      id_ok = (id < READERS);
      if (act == ACT_WRITE) begin
         ring[wr_ptr] = data;
         wr_ptr = step_ptr(wr_ptr);
         for (int k = 0; k < READERS; k++) begin
            // a full reader loses its oldest element
            if (avail[k] == DEPTH) begin
               rd_idx[k] = wr_ptr;
               if (k < MASK_FIELD_W) r.mask[k] = 1'b1;
            end else begin
               avail[k] = avail[k] + 1'b1;
            end
         end
         if (id_ok) r.count = avail[id];
         else r.status = ST_BAD_ID;
      end else if (!id_ok) begin
         r.status = ST_BAD_ID;
      end else if (avail[id] == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.read_data = ring[rd_idx[id]];
         rd_idx[id] = step_ptr(rd_idx[id]);
         avail[id] = avail[id] - 1'b1;
         r.count = avail[id];
      end
      return r;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      if (r < 110) return 0;
      if (r < 180) return $urandom_range(1, 3);
      if (r < 196) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_FIELD_W-1:0] pick_data();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   task automatic add_req(action_type a, int id, logic [DATA_FIELD_W-1:0] d);
      fifo_request_type q;
      q.action = a;
      q.reader_sel = id[ID_FIELD_W-1:0];
      q.write_data = d;
      pending_requests.push_back(q);
   endtask

   task automatic check_field(string name, logic [DATA_FIELD_W-1:0] exp_val,
                              logic [DATA_FIELD_W-1:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, got_val);
         failures++;
      end
   endtask

   // driver: after a transfer and its random gap, the next request goes out at a falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_action     <= pending_requests[0].action;
            req_reader_sel <= pending_requests[0].reader_sel;
            req_write_data <= pending_requests[0].write_data;
            void'(pending_requests.pop_front());
            req_valid      <= 1'b1;
            tx_gap = pick_gap(tx_burst);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver side stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) rx_stall = pick_gap(rx_burst);
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: check the response first, then predict the request taken at this edge
   always @(posedge clock) begin
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            rsp_seen++;
            if (owed_responses.size() == 0) begin
               $display("%0t: response with none expected, expected none actual %h %h %h %h",
                        $time, rsp_read_data, rsp_status, rsp_available_count,
                        rsp_overrun_mask);
               failures++;
            end else begin
               want = owed_responses.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("status", DATA_FIELD_W'(want.status), DATA_FIELD_W'(rsp_status));
               check_field("available_count", DATA_FIELD_W'(want.count),
                           DATA_FIELD_W'(rsp_available_count));
               check_field("overrun_mask", DATA_FIELD_W'(want.mask),
                           DATA_FIELD_W'(rsp_overrun_mask));
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            owed_responses.push_back(next_response(action_type'(req_action), req_reader_sel,
                                                   req_write_data));
         end
      end
   end

   // long receiver hold-off so the response register fills and input stalls
   initial begin
      while (rsp_seen < 300) @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      wr_ptr = '0;
      for (int k = 0; k < READERS; k++) begin
         rd_idx[k] = '0;
         avail[k] = '0;
      end

      // directed: empty reads, bad ids on both actions, data extremes, read back
      add_req(ACT_READ, 0, '0);
      add_req(ACT_READ, 7, '1);
      add_req(ACT_WRITE, 5, '0);
      add_req(ACT_WRITE, 0, '1);
      add_req(ACT_WRITE, 1, 32'ha5a5_a5a5);
      add_req(ACT_WRITE, 2, 32'h5a5a_5a5a);
      add_req(ACT_WRITE, 3, 32'h0000_0001);
      add_req(ACT_READ, 0, '0);
      add_req(ACT_READ, 1, '0);
      add_req(ACT_READ, 2, '0);
      add_req(ACT_READ, 3, '1);
      add_req(ACT_READ, 4, '0);
      add_req(ACT_WRITE, 6, 32'h8000_0000);
      add_req(ACT_READ, 0, '0);
      add_req(ACT_READ, 0, '0);
      add_req(ACT_READ, 0, '0);
      add_req(ACT_READ, 0, '0);
      add_req(ACT_READ, 0, '0);
      add_req(ACT_READ, 5, '0);
      add_req(ACT_WRITE, 7, 32'h7fff_ffff);

      // mostly writes so every reader fills and overruns; few reads, none for 0 and 1
      for (int n = 0; n < 1200; n++) begin
         if ($urandom_range(0, 99) < 92) add_req(ACT_WRITE, $urandom_range(0, 7), pick_data());
         else add_req(ACT_READ, $urandom_range(2, 7), $urandom);
      end
      // read-heavy mix over every id
      for (int n = 0; n < 400; n++) begin
         if ($urandom_range(0, 99) < 35) add_req(ACT_WRITE, $urandom_range(0, 7), pick_data());
         else add_req(ACT_READ, $urandom_range(0, 7), $urandom);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_valid) @(posedge clock);
      while (owed_responses.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
